// ----- src/itp_pkg.sv -----
// Package with operator codes, character constants and shared types of the converter.
package itp_pkg;

  // Characters with a special meaning in the infix stream.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Operator codes as they are kept on the stack.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_POW    = 3'd5,
    OP_LPAREN = 3'd6
  } op_code_t;

  localparam int CODE_W = 3;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FETCH
  } state_t;

  // Result word handed from the controller to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } emit_t;

  // Maps an input byte to its operator code; anything else, a close parenthesis too, gives OP_NONE.
  function automatic op_code_t char_to_code(input logic [7:0] c);
    op_code_t code;
    unique case (c)
      CH_PLUS:   code = OP_ADD;
      CH_MINUS:  code = OP_SUB;
      CH_STAR:   code = OP_MUL;
      CH_SLASH:  code = OP_DIV;
      CH_CARET:  code = OP_POW;
      CH_LPAREN: code = OP_LPAREN;
      default:   code = OP_NONE;
    endcase
    return code;
  endfunction

  // Precedence; an open parenthesis ranks below every operator.
  function automatic logic [1:0] code_prec(input op_code_t code);
    logic [1:0] p;
    unique case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  // Character that an operator code stands for.
  function automatic logic [7:0] code_to_char(input op_code_t code);
    logic [7:0] c;
    unique case (code)
      OP_ADD:    c = CH_PLUS;
      OP_SUB:    c = CH_MINUS;
      OP_MUL:    c = CH_STAR;
      OP_DIV:    c = CH_SLASH;
      OP_POW:    c = CH_CARET;
      OP_LPAREN: c = CH_LPAREN;
      default:   c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ----- src/itp_if.sv -----
// Valid/ready channel interfaces for infix input words and postfix result words.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_char;

  modport source (output valid, output cmd, output in_char, input ready);
  modport sink   (input valid, input cmd, input in_char, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       overflowed;

  modport source (output valid, output out_char, output last, output overflowed, input ready);
  modport sink   (input valid, input out_char, input last, input overflowed, output ready);
endinterface

// ----- src/infix_to_postfix_converter_top.sv -----
// Top level of the shunting-yard infix-to-postfix converter with its output register.
// An operand that finds the output register free goes into it and sits there from the cycle
// after it is accepted; an open parenthesis is pushed at once. Other words go to evaluation,
// and each stack entry popped passes the fetch state, except the open parenthesis that ends a
// close one. One word is taken at a time, only when idle; a full output register holds it up.
// Reset (synchronous, rst_n low) empties the stack and clears the overflow flag, not the RAM.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  itp_in_if.sink     in_if,
  itp_out_if.source  out_if
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  itp_pkg::emit_t              emit;
  logic                        out_free;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [itp_pkg::CODE_W-1:0]  mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [itp_pkg::CODE_W-1:0]  mem_rdata;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       out_ovf_r;

  itp_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .emit      (emit),
    .out_free  (out_free),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  itp_ram #(
    .WIDTH (itp_pkg::CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_r || out_if.ready;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_char_r <= emit.ch;
      out_last_r <= emit.last;
      out_ovf_r  <= emit.ovf;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_char   = out_char_r;
  assign out_if.last       = out_last_r;
  assign out_if.overflowed = out_ovf_r;

endmodule

// ----- src/itp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/itp_ctrl.sv -----
// Shunting-yard controller: reads the stack top from RAM, pops, pushes and emits words.
module itp_ctrl #(
  parameter int STACK_DEPTH = 32,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  itp_in_if.sink                   in_if,
  output itp_pkg::emit_t           emit,
  input  logic                     out_free,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [itp_pkg::CODE_W-1:0] mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  logic [itp_pkg::CODE_W-1:0] mem_rdata
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  itp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic            cmd_r;
  logic [7:0]      char_r;

  itp_pkg::op_code_t in_code;
  itp_pkg::op_code_t cur_code;
  itp_pkg::op_code_t top_code;
  logic              accept;
  logic              empty;
  logic              full;
  logic              push_req;
  itp_pkg::op_code_t push_code;

  assign in_if.ready = (state_r == itp_pkg::ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign in_code     = itp_pkg::char_to_code(in_if.in_char);
  assign cur_code    = itp_pkg::char_to_code(char_r);
  assign top_code    = itp_pkg::op_code_t'(mem_rdata);
  assign empty       = (count_r == '0);
  assign full        = (count_r == FULL_COUNT);

  // The read address always follows the current top of stack.
  assign mem_raddr = empty ? '0 : AW'(count_r - CW'(1));

  // A push writes one entry above the top unless the stack is full.
  assign mem_we    = push_req && !full;
  assign mem_waddr = AW'(count_r);
  assign mem_wdata = push_code;

  // Hold the accepted word for the evaluation cycles.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_if.cmd;
      char_r <= in_if.in_char;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itp_pkg::ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Next state, stack updates and emitted words.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    push_req  = 1'b0;
    push_code = itp_pkg::OP_NONE;
    emit      = '0;

    unique case (state_r)
      itp_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_if.cmd && in_if.in_char != itp_pkg::CH_RPAREN
              && in_code == itp_pkg::OP_NONE && out_free) begin
            // Operand passes straight through.
            emit.valid = 1'b1;
            emit.ch    = in_if.in_char;
          end else if (!in_if.cmd && in_code == itp_pkg::OP_LPAREN) begin
            push_req  = 1'b1;
            push_code = itp_pkg::OP_LPAREN;
          end else begin
            // The top-of-stack read issued this cycle is ready next cycle.
            state_nxt = itp_pkg::ST_EVAL;
          end
        end
      end

      itp_pkg::ST_EVAL: begin
        if (cmd_r) begin
          // Flush: pop everything, drop open parentheses, then the end marker.
          if (!empty) begin
            if (top_code == itp_pkg::OP_LPAREN) begin
              count_nxt = count_r - CW'(1);
              state_nxt = itp_pkg::ST_FETCH;
            end else if (out_free) begin
              emit.valid = 1'b1;
              emit.ch    = itp_pkg::code_to_char(top_code);
              count_nxt  = count_r - CW'(1);
              state_nxt  = itp_pkg::ST_FETCH;
            end
          end else if (out_free) begin
            emit.valid = 1'b1;
            emit.ch    = itp_pkg::CH_NUL;
            emit.last  = 1'b1;
            emit.ovf   = ovf_r;
            ovf_nxt    = 1'b0;
            state_nxt  = itp_pkg::ST_IDLE;
          end
        end else if (char_r == itp_pkg::CH_RPAREN) begin
          // Close parenthesis: pop to the matching open one or to empty.
          if (empty) begin
            state_nxt = itp_pkg::ST_IDLE;
          end else if (top_code == itp_pkg::OP_LPAREN) begin
            count_nxt = count_r - CW'(1);
            state_nxt = itp_pkg::ST_IDLE;
          end else if (out_free) begin
            emit.valid = 1'b1;
            emit.ch    = itp_pkg::code_to_char(top_code);
            count_nxt  = count_r - CW'(1);
            state_nxt  = itp_pkg::ST_FETCH;
          end
        end else if (cur_code == itp_pkg::OP_NONE) begin
          // Operand that found the output register busy at accept time.
          if (out_free) begin
            emit.valid = 1'b1;
            emit.ch    = char_r;
            state_nxt  = itp_pkg::ST_IDLE;
          end
        end else begin
          // Operator: pop while the top binds at least as tightly, then push.
          if (!empty && itp_pkg::code_prec(top_code) >= itp_pkg::code_prec(cur_code)) begin
            if (out_free) begin
              emit.valid = 1'b1;
              emit.ch    = itp_pkg::code_to_char(top_code);
              count_nxt  = count_r - CW'(1);
              state_nxt  = itp_pkg::ST_FETCH;
            end
          end else begin
            push_req  = 1'b1;
            push_code = cur_code;
            state_nxt = itp_pkg::ST_IDLE;
          end
        end
      end

      itp_pkg::ST_FETCH: begin
        // Wait for the read of the new top of stack.
        state_nxt = itp_pkg::ST_EVAL;
      end

      default: begin
        state_nxt = itp_pkg::ST_IDLE;
      end
    endcase

    // A push onto a full stack is dropped and remembered.
    if (push_req) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("stack count beyond depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("word emitted while output register is occupied");

  a_marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.last) |-> (count_r == '0))
    else $error("end marker emitted with a non-empty stack");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (count_r < FULL_COUNT))
    else $error("stack write past its depth");

  a_ovf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.last) |=> !ovf_r)
    else $error("overflow flag survived the end marker");
`endif

endmodule

// ----- tb/infix_to_postfix_converter_top_tb.sv -----
// Testbench for the infix-to-postfix converter: random and directed infix words against a predictor.
module infix_to_postfix_converter_top_tb;

  localparam int DEPTH = 32;

  // Tracks the operator stack of the converter and the postfix words it must emit.
  class postfix_tracker;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
    } word_t;

    itp_pkg::op_code_t stk[DEPTH];
    int unsigned       depth;
    bit                ovf_seen;
    word_t             due[$];
    int                fails;

    function new();
      depth    = 0;
      ovf_seen = 1'b0;
      fails    = 0;
    endfunction

    // An open parenthesis ranks below every operator, so no operator pops it.
    function int rank(itp_pkg::op_code_t c);
      case (c)
        itp_pkg::OP_ADD, itp_pkg::OP_SUB: return 1;
        itp_pkg::OP_MUL, itp_pkg::OP_DIV: return 2;
        itp_pkg::OP_POW:                  return 3;
        default:                          return -1;
      endcase
    endfunction

    function itp_pkg::op_code_t classify(logic [7:0] ch);
      case (ch)
        itp_pkg::CH_PLUS:   return itp_pkg::OP_ADD;
        itp_pkg::CH_MINUS:  return itp_pkg::OP_SUB;
        itp_pkg::CH_STAR:   return itp_pkg::OP_MUL;
        itp_pkg::CH_SLASH:  return itp_pkg::OP_DIV;
        itp_pkg::CH_CARET:  return itp_pkg::OP_POW;
        itp_pkg::CH_LPAREN: return itp_pkg::OP_LPAREN;
        default:            return itp_pkg::OP_NONE;
      endcase
    endfunction

    function logic [7:0] glyph(itp_pkg::op_code_t c);
      case (c)
        itp_pkg::OP_ADD: return itp_pkg::CH_PLUS;
        itp_pkg::OP_SUB: return itp_pkg::CH_MINUS;
        itp_pkg::OP_MUL: return itp_pkg::CH_STAR;
        itp_pkg::OP_DIV: return itp_pkg::CH_SLASH;
        itp_pkg::OP_POW: return itp_pkg::CH_CARET;
        default:         return itp_pkg::CH_NUL;
      endcase
    endfunction

    function void put(logic [7:0] ch, logic last, logic ovf);
      word_t w;
      w.ch   = ch;
      w.last = last;
      w.ovf  = ovf;
      due.push_back(w);
    endfunction

    // A push onto a full stack is lost and leaves the sticky flag set.
    function void push_op(itp_pkg::op_code_t c);
      if (depth >= DEPTH) begin
        ovf_seen = 1'b1;
      end else begin
        stk[depth] = c;
        depth++;
      end
    endfunction

    // Works out the postfix words caused by one accepted infix word.
    function void note_infix(logic cmd, logic [7:0] ch);
      itp_pkg::op_code_t code;
      code = classify(ch);
      if (cmd) begin
        // Flush everything; stray open parentheses vanish silently.
        while (depth > 0) begin
          depth--;
          if (stk[depth] != itp_pkg::OP_LPAREN) put(glyph(stk[depth]), 1'b0, 1'b0);
        end
        put(itp_pkg::CH_NUL, 1'b1, ovf_seen);
        ovf_seen = 1'b0;
      end else if (ch == itp_pkg::CH_RPAREN) begin
        // Pop down to the matching parenthesis, or to empty when there is none.
        while (depth > 0) begin
          depth--;
          if (stk[depth] == itp_pkg::OP_LPAREN) break;
          put(glyph(stk[depth]), 1'b0, 1'b0);
        end
      end else if (code == itp_pkg::OP_NONE) begin
        put(ch, 1'b0, 1'b0);
      end else if (code == itp_pkg::OP_LPAREN) begin
        push_op(code);
      end else begin
        while (depth > 0 && rank(stk[depth - 1]) >= rank(code)) begin
          depth--;
          put(glyph(stk[depth]), 1'b0, 1'b0);
        end
        push_op(code);
      end
    endfunction

    // Compares an accepted postfix word with the oldest one still due.
    function void check_postfix(logic [7:0] ch, logic last, logic ovf);
      word_t want;
      if (due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected word: char %h last %b overflowed %b", ch, last, ovf);
        return;
      end
      want = due.pop_front();
      if (want.ch !== ch || want.last !== last || want.ovf !== ovf) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected char %h last %b overflowed %b, got %h %b %b",
                   want.ch, want.last, want.ovf, ch, last, ovf);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  itp_in_if  in_bus ();
  itp_out_if out_bus ();

  postfix_tracker tracker;

  bit steady;
  int stall_req;
  int words_sent;

  infix_to_postfix_converter_top #(.STACK_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off when requested.
  initial begin
    int hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req > 0) begin
        hold = stall_req;
        stall_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // Every accepted result word is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      tracker.check_postfix(out_bus.out_char, out_bus.last, out_bus.overflowed);
  end

  // Offers one word, with random idle cycles first, and waits until it is taken.
  task automatic send_word(input logic cmd, input logic [7:0] ch);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.cmd     <= cmd;
    in_bus.in_char <= ch;
    do @(posedge clk); while (!in_bus.ready);
    tracker.note_infix(cmd, ch);
    words_sent++;
  endtask

  function automatic bit is_special(logic [7:0] ch);
    return ch == itp_pkg::CH_PLUS || ch == itp_pkg::CH_MINUS || ch == itp_pkg::CH_STAR ||
           ch == itp_pkg::CH_SLASH || ch == itp_pkg::CH_CARET ||
           ch == itp_pkg::CH_LPAREN || ch == itp_pkg::CH_RPAREN;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (is_special(ch)) ch = 8'($urandom_range(0, 255));
    return ch;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_STAR;
      3:       return itp_pkg::CH_SLASH;
      default: return itp_pkg::CH_CARET;
    endcase
  endfunction

  // A balanced expression with random operands, operators and nesting.
  task automatic send_formula();
    int operands, open;
    operands = $urandom_range(1, 10);
    open = 0;
    for (int i = 0; i < operands; i++) begin
      while (open < 5 && $urandom_range(0, 3) == 0) begin
        send_word(1'b0, itp_pkg::CH_LPAREN);
        open++;
      end
      send_word(1'b0, pick_operand());
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        send_word(1'b0, itp_pkg::CH_RPAREN);
        open--;
      end
      if (i != operands - 1) send_word(1'b0, pick_operator());
    end
    while (open > 0) begin
      send_word(1'b0, itp_pkg::CH_RPAREN);
      open--;
    end
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Tokens in any order, so parentheses are often unmatched.
  task automatic send_broken();
    int n;
    n = $urandom_range(3, 15);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       send_word(1'b0, pick_operand());
        1:       send_word(1'b0, pick_operator());
        2:       send_word(1'b0, itp_pkg::CH_LPAREN);
        default: send_word(1'b0, itp_pkg::CH_RPAREN);
      endcase
    end
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Arbitrary bytes with an occasional end word.
  task automatic send_noise();
    int n;
    n = $urandom_range(3, 10);
    repeat (n) send_word($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
  endtask

  // Mostly pushes, so the stack runs near or past its depth.
  task automatic send_deep();
    int n;
    n = $urandom_range(30, 40);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_word(1'b0, itp_pkg::CH_LPAREN);
        6, 7:             send_word(1'b0, pick_operator());
        default:          send_word(1'b0, pick_operand());
      endcase
    end
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Main sequence: reset, directed words, pressure, then random expressions.
  initial begin
    tracker = new();
    steady = 1'b0;
    stall_req = 0;
    words_sent = 0;
    in_bus.valid = 1'b0;
    in_bus.cmd = 1'b0;
    in_bus.in_char = itp_pkg::CH_NUL;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme operand bytes, then every operator and both parentheses.
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, itp_pkg::CH_LPAREN);
    send_word(1'b0, "a");
    send_word(1'b0, itp_pkg::CH_PLUS);
    send_word(1'b0, "b");
    send_word(1'b0, itp_pkg::CH_RPAREN);
    send_word(1'b0, itp_pkg::CH_STAR);
    send_word(1'b0, "c");
    send_word(1'b0, itp_pkg::CH_CARET);
    send_word(1'b0, "d");
    send_word(1'b0, itp_pkg::CH_MINUS);
    send_word(1'b0, "e");
    send_word(1'b0, itp_pkg::CH_SLASH);
    send_word(1'b0, "f");
    send_word(1'b1, 8'h00);
    // A closing parenthesis with no partner, then open ones left at the end.
    send_word(1'b0, "x");
    send_word(1'b0, itp_pkg::CH_MINUS);
    send_word(1'b0, itp_pkg::CH_RPAREN);
    send_word(1'b0, itp_pkg::CH_LPAREN);
    send_word(1'b0, itp_pkg::CH_LPAREN);
    send_word(1'b0, "y");
    send_word(1'b1, 8'hFF);

    // The receiver holds off while operands keep coming, so the input stalls.
    stall_req = 300;
    repeat (12) send_word(1'b0, pick_operand());

    // Fill the stack completely, then lose one push to a full stack.
    repeat (16) begin
      send_word(1'b0, itp_pkg::CH_LPAREN);
      send_word(1'b0, itp_pkg::CH_PLUS);
    end
    send_word(1'b0, "q");
    send_word(1'b0, itp_pkg::CH_STAR);
    send_word(1'b1, 8'h55);

    while (words_sent < 250) begin
      steady = (words_sent >= 120 && words_sent < 180);
      case ($urandom_range(0, 99)) inside
        [0:69]:  send_formula();
        [70:84]: send_broken();
        [85:94]: send_noise();
        default: send_deep();
      endcase
    end
    steady = 1'b0;
    send_word(1'b1, 8'h00);
    @(negedge clk);
    in_bus.valid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- infix_to_postfix_converter_top.f -----
src/itp_pkg.sv
src/itp_if.sv
src/itp_ram.sv
src/itp_ctrl.sv
src/infix_to_postfix_converter_top.sv
tb/infix_to_postfix_converter_top_tb.sv
